/* rtl/wsfb_pkg.sv */
// Shared types and constants for the wheel speed frame builder.
// No dependencies; used by the channel interfaces and every module.
package wsfb_pkg;

   localparam int SpeedWidth   = 10;
   localparam int WordWidth    = 16;
   localparam int ByteWidth    = 8;
   localparam int CsrIdxWidth  = 2;
   localparam int CsrDataWidth = 8;

   // |rpm| * 3200 / 144 == |rpm| * 200 / 9, done as a reciprocal multiply.
   // (200 * ceil(2^20 / 9)) >> 20 is exact for every magnitude up to 512.
   localparam int RecipShift   = 20;
   localparam int RecipWidth   = 25;
   localparam logic [RecipWidth-1:0] RecipMult = 25'd23301800;
   localparam int ProdWidth    = SpeedWidth + RecipWidth;
   localparam int MagWidth     = WordWidth - 1;

   // Register indexes of the CSR write port.
   localparam logic [CsrIdxWidth-1:0] CsrHeaderFirst  = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CsrHeaderSecond = 2'd1;

   // Byte position inside the nine-byte drive frame.
   typedef enum logic [3:0] {
      PosHeader0  = 4'd0,
      PosHeader1  = 4'd1,
      PosLeftHi   = 4'd2,
      PosLeftLo   = 4'd3,
      PosRightHi  = 4'd4,
      PosRightLo  = 4'd5,
      PosModeHi   = 4'd6,
      PosModeLo   = 4'd7,
      PosChecksum = 4'd8
   } byte_pos_type;

   // Frame load request from the command stage to the serializer.
   typedef struct packed {
      logic                 load;
      logic [ByteWidth-1:0] header0;
      logic [ByteWidth-1:0] header1;
      logic [WordWidth-1:0] word_left;
      logic [WordWidth-1:0] word_right;
   } load_type;

   // Serializer status back to the command stage.
   typedef struct packed {
      logic can_load;
   } ser_status_type;

endpackage

/* rtl/wsfb_channels.sv */
// Valid/ready channel interfaces for command and frame byte transactions.
// Depends on wsfb_pkg for field widths.
interface wsfb_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [wsfb_pkg::SpeedWidth-1:0] speed_left;
   logic signed [wsfb_pkg::SpeedWidth-1:0] speed_right;

   modport source (output valid, output speed_left, output speed_right, input ready);
   modport sink   (input valid, input speed_left, input speed_right, output ready);
endinterface

interface wsfb_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [wsfb_pkg::ByteWidth-1:0] frame_byte;
   logic                           frame_last;

   modport source (output valid, output frame_byte, output frame_last, input ready);
   modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

/* rtl/wsfb_speed_map.sv */
// Maps one signed whole-rpm speed to the 16-bit sign-magnitude ESC word.
// Depends on wsfb_pkg for widths and the reciprocal constant.
module wsfb_speed_map (
   input  logic signed [wsfb_pkg::SpeedWidth-1:0] speed,
   output logic        [wsfb_pkg::WordWidth-1:0]  word
);

   logic                              neg;
   logic [wsfb_pkg::SpeedWidth-1:0]   mag;
   logic [wsfb_pkg::ProdWidth-1:0]    prod;
   logic [wsfb_pkg::MagWidth-1:0]     scaled;

   // -512 negates to 10'h200, which read unsigned is the right magnitude.
   assign neg    = speed[wsfb_pkg::SpeedWidth-1];
   assign mag    = neg ? (~speed + 1'b1) : speed;
   assign prod   = wsfb_pkg::ProdWidth'(mag) * wsfb_pkg::ProdWidth'(wsfb_pkg::RecipMult);
   assign scaled = prod[wsfb_pkg::RecipShift +: wsfb_pkg::MagWidth];
   assign word   = {neg, scaled};

endmodule

/* rtl/wsfb_serializer.sv */
// Frame register and byte serializer with running checksum.
// Depends on wsfb_pkg and the wsfb_rsp_if channel.
module wsfb_serializer (
   input  logic                     clock,
   input  logic                     reset,
   input  wsfb_pkg::load_type       load_req,
   output wsfb_pkg::ser_status_type status,
   wsfb_rsp_if.source               rsp_ch
);

   logic                           busy_ff, busy_in;
   wsfb_pkg::byte_pos_type         pos_ff, pos_in;
   logic [wsfb_pkg::ByteWidth-1:0] sum_ff, sum_in;
   logic [wsfb_pkg::ByteWidth-1:0] hdr0_ff, hdr0_in;
   logic [wsfb_pkg::ByteWidth-1:0] hdr1_ff, hdr1_in;
   logic [wsfb_pkg::WordWidth-1:0] left_ff, left_in;
   logic [wsfb_pkg::WordWidth-1:0] right_ff, right_in;
   logic [wsfb_pkg::ByteWidth-1:0] cur_byte;
   logic                           fire;
   logic                           at_end;

   assign fire   = busy_ff && rsp_ch.ready;
   assign at_end = (pos_ff == wsfb_pkg::PosChecksum);
   assign status.can_load = !busy_ff || (fire && at_end);

   always_comb begin
      case (pos_ff)
         wsfb_pkg::PosHeader0:  cur_byte = hdr0_ff;
         wsfb_pkg::PosHeader1:  cur_byte = hdr1_ff;
         wsfb_pkg::PosLeftHi:   cur_byte = left_ff[15:8];
         wsfb_pkg::PosLeftLo:   cur_byte = left_ff[7:0];
         wsfb_pkg::PosRightHi:  cur_byte = right_ff[15:8];
         wsfb_pkg::PosRightLo:  cur_byte = right_ff[7:0];
         wsfb_pkg::PosChecksum: cur_byte = sum_ff;
         default:               cur_byte = '0;   // mode bytes are always zero
      endcase
   end

   assign rsp_ch.valid      = busy_ff;
   assign rsp_ch.frame_byte = cur_byte;
   assign rsp_ch.frame_last = at_end;

   always_comb begin
      busy_in  = busy_ff;
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      hdr0_in  = hdr0_ff;
      hdr1_in  = hdr1_ff;
      left_in  = left_ff;
      right_in = right_ff;
      if (fire) begin
         if (at_end) begin
            busy_in = 1'b0;
         end else begin
            pos_in = wsfb_pkg::byte_pos_type'(pos_ff + 4'd1);
            sum_in = sum_ff + cur_byte;
         end
      end
      if (load_req.load) begin
         busy_in  = 1'b1;
         pos_in   = wsfb_pkg::PosHeader0;
         sum_in   = '0;
         hdr0_in  = load_req.header0;
         hdr1_in  = load_req.header1;
         left_in  = load_req.word_left;
         right_in = load_req.word_right;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= wsfb_pkg::PosHeader0;
         sum_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
         sum_ff  <= sum_in;
      end
      hdr0_ff  <= hdr0_in;
      hdr1_ff  <= hdr1_in;
      left_ff  <= left_in;
      right_ff <= right_in;
   end

`ifndef SYNTH
   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      load_req.load |-> (!busy_ff || (fire && at_end)))
      else $error("frame loaded over an unfinished frame");

   a_mid_frame_stays_busy: assert property (@(posedge clock) disable iff (reset)
      (fire && !at_end) |=> busy_ff)
      else $error("serializer dropped out mid frame");

   a_stall_holds_pos: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !rsp_ch.ready) |=> (busy_ff && $stable(pos_ff) && $stable(sum_ff)))
      else $error("byte position moved while stalled");

   a_end_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (fire && at_end && !load_req.load) |=> !busy_ff)
      else $error("serializer stayed busy after checksum byte");
`endif

endmodule

/* rtl/wheel_speed_frame_builder_unit.sv */
// Wheel speed frame builder, top level: command register, CSRs, speed
// mapping and the byte serializer. Depends on wsfb_pkg, wsfb_channels,
// wsfb_speed_map and wsfb_serializer.
//
// Usage:
//  - req_ch carries one drive command per transaction: two signed 10-bit
//    whole-rpm speeds. rsp_ch returns nine byte transactions per command:
//    header_first, header_second, left hi/lo, right hi/lo, two zero mode
//    bytes and the 8-bit wrapping checksum, which has frame_last set.
//  - csr_wr_en/csr_index/csr_wr_data write the two header bytes (index 0
//    and 1, other indexes ignored). Write only while no frame is pending.
//  - First byte: an accepted command passes through the command register
//    and then the serializer frame register before the first byte of its
//    frame is valid on rsp_ch, when the serializer is free.
//  - Throughput: one byte per cycle while the receiver is ready, set by
//    the single byte-wide output port. One command waits in the input
//    register while the previous frame drains, so frames go back to back.
//  - Receiver stall: the current byte holds on rsp_ch; once the input
//    register is also full, req_ch.ready drops.
//  - Reset clears the headers to zero and empties both stages.
module wheel_speed_frame_builder_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   wsfb_req_if.sink                             req_ch,
   wsfb_rsp_if.source                           rsp_ch,
   input  logic                                 csr_wr_en,
   input  logic [wsfb_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [wsfb_pkg::CsrDataWidth-1:0]    csr_wr_data
);

   logic [wsfb_pkg::ByteWidth-1:0]         hdr0_ff, hdr0_in;
   logic [wsfb_pkg::ByteWidth-1:0]         hdr1_ff, hdr1_in;

   // command register
   logic                                   cmd_valid_ff, cmd_valid_in;
   logic signed [wsfb_pkg::SpeedWidth-1:0] left_ff, left_in;
   logic signed [wsfb_pkg::SpeedWidth-1:0] right_ff, right_in;

   logic [wsfb_pkg::WordWidth-1:0]         word_left;
   logic [wsfb_pkg::WordWidth-1:0]         word_right;
   wsfb_pkg::load_type                     load_req;
   wsfb_pkg::ser_status_type               ser_status;
   logic                                   req_take;

   // CSR decode
   always_comb begin
      hdr0_in = hdr0_ff;
      hdr1_in = hdr1_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            wsfb_pkg::CsrHeaderFirst:  hdr0_in = csr_wr_data;
            wsfb_pkg::CsrHeaderSecond: hdr1_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   // Command moves to the serializer as soon as it can take a new frame.
   assign load_req.load       = cmd_valid_ff && ser_status.can_load;
   assign load_req.header0    = hdr0_ff;
   assign load_req.header1    = hdr1_ff;
   assign load_req.word_left  = word_left;
   assign load_req.word_right = word_right;

   assign req_ch.ready = !cmd_valid_ff || ser_status.can_load;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      cmd_valid_in = cmd_valid_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      if (load_req.load) begin
         cmd_valid_in = 1'b0;
      end
      if (req_take) begin
         cmd_valid_in = 1'b1;
         left_in      = req_ch.speed_left;
         right_in     = req_ch.speed_right;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr0_ff      <= '0;
         hdr1_ff      <= '0;
         cmd_valid_ff <= 1'b0;
      end else begin
         hdr0_ff      <= hdr0_in;
         hdr1_ff      <= hdr1_in;
         cmd_valid_ff <= cmd_valid_in;
      end
      left_ff  <= left_in;
      right_ff <= right_in;
   end

   wsfb_speed_map u_map_left (
      .speed (left_ff),
      .word  (word_left)
   );

   wsfb_speed_map u_map_right (
      .speed (right_ff),
      .word  (word_right)
   );

   wsfb_serializer u_ser (
      .clock    (clock),
      .reset    (reset),
      .load_req (load_req),
      .status   (ser_status),
      .rsp_ch   (rsp_ch)
   );

endmodule

/* verif/wheel_speed_frame_builder_unit_tb.sv */
// Self-checking bench for wheel_speed_frame_builder_unit: command stream in, frame bytes out.
// Depends on wsfb_pkg, wsfb_channels and the unit RTL; needs no other file.
module wheel_speed_frame_builder_unit_tb;

   // frame mapping constants: |rpm| * 3200 / 144, sign flag on negative speeds
   localparam int          RawFullScale = 3200;
   localparam int          RpmFullScale = 144;
   localparam logic [15:0] SignFlag     = 16'h8000;
   localparam int          FrameLen     = 9;

   // indexes past the two header registers; writes there must be dropped
   localparam logic [wsfb_pkg::CsrIdxWidth-1:0] CsrSpareLo = 2'd2;
   localparam logic [wsfb_pkg::CsrIdxWidth-1:0] CsrSpareHi = 2'd3;

   localparam int ResetCycles  = 12;
   localparam int DrainCycles  = 8;
   localparam int HoldOffLen   = 400;   // long receiver back-pressure stretch
   localparam int RandomPerPhase = 40;

   typedef enum int {
      TrafficSteady,
      TrafficSenderIdle,
      TrafficReceiverStall,
      TrafficBothIdle,
      TrafficPressure
   } traffic_mode_type;

   typedef struct {
      logic signed [wsfb_pkg::SpeedWidth-1:0] left;
      logic signed [wsfb_pkg::SpeedWidth-1:0] right;
   } drive_cmd_type;

   typedef struct {
      logic [wsfb_pkg::ByteWidth-1:0] frame_byte;
      logic                           frame_last;
   } frame_byte_type;

   logic clock;
   logic reset;
   logic                              csr_wr_en;
   logic [wsfb_pkg::CsrIdxWidth-1:0]  csr_index;
   logic [wsfb_pkg::CsrDataWidth-1:0] csr_wr_data;

   wsfb_req_if req_ch ();
   wsfb_rsp_if rsp_ch ();

   wheel_speed_frame_builder_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // shadow copy of the header registers, as the predictor sees them
   logic [wsfb_pkg::ByteWidth-1:0] hdr_first_shadow;
   logic [wsfb_pkg::ByteWidth-1:0] hdr_second_shadow;

   drive_cmd_type  drive_cmd_backlog[$];   // commands waiting for the driver
   frame_byte_type frame_bytes_due[$];     // predicted bytes, oldest first

   int               cmds_issued;
   int               cmds_accepted;
   int               error_count;
   traffic_mode_type traffic;
   int               req_idle_pct;
   int               rsp_stall_pct;
   int               hold_off_cycles;
   logic             req_fire;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Sign-magnitude speed word; truncating divide, sign flag even when the
   // magnitude alone would be small.
   function automatic logic [15:0] rpm_to_speed_word(
      input logic signed [wsfb_pkg::SpeedWidth-1:0] rpm);
      int          mag;
      logic [15:0] word;
      mag  = (rpm < 0) ? -int'(rpm) : int'(rpm);
      word = 16'((mag * RawFullScale) / RpmFullScale);
      if (rpm < 0) begin
         word = word + SignFlag;
      end
      return word;
   endfunction

   // Nine bytes in send order; checksum is the wrapping sum of the first eight.
   function automatic void build_drive_frame(input drive_cmd_type cmd);
      logic [15:0]                    word_left;
      logic [15:0]                    word_right;
      logic [wsfb_pkg::ByteWidth-1:0] bytes[FrameLen];
      logic [wsfb_pkg::ByteWidth-1:0] sum;
      frame_byte_type                 entry;
      word_left  = rpm_to_speed_word(cmd.left);
      word_right = rpm_to_speed_word(cmd.right);
      bytes[0] = hdr_first_shadow;
      bytes[1] = hdr_second_shadow;
      bytes[2] = word_left[15:8];
      bytes[3] = word_left[7:0];
      bytes[4] = word_right[15:8];
      bytes[5] = word_right[7:0];
      bytes[6] = '0;
      bytes[7] = '0;
      sum = '0;
      for (int k = 0; k < FrameLen - 1; k++) begin
         sum = sum + bytes[k];
      end
      bytes[8] = sum;
      for (int k = 0; k < FrameLen; k++) begin
         entry.frame_byte = bytes[k];
         entry.frame_last = (k == FrameLen - 1);
         frame_bytes_due.push_back(entry);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driver: one command transaction at a time, changed at falling edges
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      drive_cmd_type cmd;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_fire) begin
         if (drive_cmd_backlog.size() > 0 && $urandom_range(99) >= req_idle_pct) begin
            cmd = drive_cmd_backlog.pop_front();
            req_ch.valid       <= 1'b1;
            req_ch.speed_left  <= cmd.left;
            req_ch.speed_right <= cmd.right;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver ready; in the pressure phase it first holds off for a long
   // stretch so the input register fills and req ready must drop.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (traffic == TrafficPressure && hold_off_cycles < HoldOffLen) begin
         rsp_ch.ready    <= 1'b0;
         hold_off_cycles <= hold_off_cycles + 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: accepted commands feed the predictor, each accepted byte is
   // checked against the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      drive_cmd_type  cmd;
      frame_byte_type due;
      req_fire = !reset && req_ch.valid && req_ch.ready;
      if (req_fire) begin
         cmd.left  = req_ch.speed_left;
         cmd.right = req_ch.speed_right;
         build_drive_frame(cmd);
         cmds_accepted++;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (frame_bytes_due.size() == 0) begin
            $error("frame byte transaction with nothing due: frame_byte=%02h frame_last=%0b",
                   rsp_ch.frame_byte, rsp_ch.frame_last);
            error_count++;
         end else begin
            due = frame_bytes_due.pop_front();
            if (rsp_ch.frame_byte !== due.frame_byte) begin
               $error("frame_byte mismatch: expected %02h, actual %02h",
                      due.frame_byte, rsp_ch.frame_byte);
               error_count++;
            end
            if (rsp_ch.frame_last !== due.frame_last) begin
               $error("frame_last mismatch: expected %0b, actual %0b",
                      due.frame_last, rsp_ch.frame_last);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_cmd(input int left, input int right);
      drive_cmd_type cmd;
      cmd.left  = left[wsfb_pkg::SpeedWidth-1:0];
      cmd.right = right[wsfb_pkg::SpeedWidth-1:0];
      drive_cmd_backlog.push_back(cmd);
      cmds_issued++;
   endtask

   // mix of full 10-bit range, nominal range, near zero and the extremes
   function automatic int random_rpm();
      int pick;
      pick = $urandom_range(3);
      case (pick)
         0: return int'($signed(10'($urandom_range(1023))));
         1: return int'($urandom_range(288)) - 144;
         2: return int'($urandom_range(16)) - 8;
         default: begin
            case ($urandom_range(3))
               0: return -512;
               1: return -511;
               2: return 511;
               default: return 0;
            endcase
         end
      endcase
   endfunction

   task automatic write_header_reg(input logic [wsfb_pkg::CsrIdxWidth-1:0] index,
                                   input logic [wsfb_pkg::CsrDataWidth-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (index == wsfb_pkg::CsrHeaderFirst) begin
         hdr_first_shadow = data;
      end else if (index == wsfb_pkg::CsrHeaderSecond) begin
         hdr_second_shadow = data;
      end
   endtask

   task automatic set_traffic(input traffic_mode_type mode);
      traffic = mode;
      case (mode)
         TrafficSenderIdle:    begin req_idle_pct = 51; rsp_stall_pct = 0;  end
         TrafficReceiverStall: begin req_idle_pct = 0;  rsp_stall_pct = 51; end
         TrafficBothIdle:      begin req_idle_pct = 26; rsp_stall_pct = 26; end
         default:              begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
      endcase
   endtask

   // block is idle once every command is in and every byte has come out
   task automatic wait_frames_drained();
      while (cmds_accepted != cmds_issued || frame_bytes_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic queue_random_cmds(input int count);
      for (int n = 0; n < count; n++) begin
         queue_cmd(random_rpm(), random_rpm());
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = '0;
      csr_wr_data        = '0;
      req_ch.valid       = 1'b0;
      req_ch.speed_left  = '0;
      req_ch.speed_right = '0;
      rsp_ch.ready       = 1'b0;
      req_fire           = 1'b0;
      hdr_first_shadow   = '0;
      hdr_second_shadow  = '0;
      cmds_issued        = 0;
      cmds_accepted      = 0;
      error_count        = 0;
      hold_off_cycles    = 0;
      set_traffic(TrafficSteady);

      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, headers still at their reset value
      queue_cmd(0, 0);
      queue_cmd(511, -511);
      queue_cmd(-512, 511);       // largest magnitude, still fits in 15 bits
      queue_cmd(-512, -512);
      queue_cmd(1, -1);           // smallest nonzero, sign flag on the negative
      queue_cmd(-1, 1);
      queue_cmd(144, -144);       // nominal full scale
      queue_cmd(-144, 144);
      queue_cmd(341, -342);       // alternating bit patterns
      queue_cmd(-342, 341);
      queue_cmd(255, -256);
      queue_cmd(256, -255);
      queue_cmd(72, -72);
      queue_cmd(9, -9);           // exact division
      queue_cmd(0, -1);
      queue_cmd(-1, 0);
      queue_cmd(100, 37);
      queue_cmd(-100, -37);
      wait_frames_drained();

      // headers at the top extreme, idle sender
      write_header_reg(wsfb_pkg::CsrHeaderFirst, 8'hFF);
      write_header_reg(wsfb_pkg::CsrHeaderSecond, 8'hFF);
      set_traffic(TrafficSenderIdle);
      queue_random_cmds(RandomPerPhase);
      wait_frames_drained();

      // mixed headers; writes to unused indexes must leave them alone
      write_header_reg(wsfb_pkg::CsrHeaderFirst, 8'h5A);
      write_header_reg(wsfb_pkg::CsrHeaderSecond, 8'hC3);
      write_header_reg(CsrSpareLo, 8'h11);
      write_header_reg(CsrSpareHi, 8'hEE);
      set_traffic(TrafficReceiverStall);
      queue_random_cmds(RandomPerPhase);
      wait_frames_drained();

      write_header_reg(wsfb_pkg::CsrHeaderFirst, 8'($urandom_range(255)));
      write_header_reg(wsfb_pkg::CsrHeaderSecond, 8'($urandom_range(255)));
      set_traffic(TrafficBothIdle);
      queue_random_cmds(RandomPerPhase);
      wait_frames_drained();

      // receiver holds off while the sender keeps offering transactions
      write_header_reg(wsfb_pkg::CsrHeaderFirst, 8'hFF);
      write_header_reg(wsfb_pkg::CsrHeaderSecond, 8'h00);
      set_traffic(TrafficPressure);
      queue_random_cmds(RandomPerPhase);
      wait_frames_drained();

      write_header_reg(wsfb_pkg::CsrHeaderFirst, 8'($urandom_range(255)));
      write_header_reg(wsfb_pkg::CsrHeaderSecond, 8'($urandom_range(255)));
      set_traffic(TrafficSteady);
      queue_random_cmds(RandomPerPhase);
      wait_frames_drained();

      repeat (20) @(negedge clock);
      if (error_count == 0) begin
         $display("wheel_speed_frame_builder_unit regression: pass");
      end else begin
         $display("wheel_speed_frame_builder_unit regression: fail");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #400000;
      $display("wheel_speed_frame_builder_unit regression: fail");
      $finish;
   end

endmodule
